FILE: rtl/bvmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the supply monitor with running median.
// No dependencies; the top level imports it.

package bvmm_pkg;

    // Field widths
    localparam int c_CODE_W   = 10;
    localparam int c_MV_W     = 16;
    localparam int c_PCT_W    = 8;
    localparam int c_LEVEL_W  = 4;
    localparam int c_NUM_W    = 24;

    // Configuration port
    localparam int c_CFG_IDX_W  = 2;
    localparam int c_CFG_DATA_W = 24;

    localparam logic [c_CFG_IDX_W-1:0] c_REG_REF_NUM = 2'd0;
    localparam logic [c_CFG_IDX_W-1:0] c_REG_MIN_MV  = 2'd1;
    localparam logic [c_CFG_IDX_W-1:0] c_REG_MAX_MV  = 2'd2;

    localparam logic [c_NUM_W-1:0] c_RST_REF_NUM = 24'd1125300;
    localparam logic [c_MV_W-1:0]  c_RST_MIN_MV  = 16'd3000;
    localparam logic [c_MV_W-1:0]  c_RST_MAX_MV  = 16'd4200;

    // Divider: one quotient bit per step over the full dividend
    localparam int             c_DIV_STEPS = 24;
    localparam logic [4:0]     c_DIV_LAST  = 5'(c_DIV_STEPS - 1);

    // Percent scale, saturation limits and icon bands
    localparam logic [6:0]              c_PCT_SCALE = 7'd100;
    localparam logic signed [c_PCT_W-1:0] c_PCT_SAT_HI = 8'sd127;
    localparam logic signed [c_PCT_W-1:0] c_PCT_SAT_LO = -8'sd128;
    localparam logic signed [c_PCT_W-1:0] c_PCT_FULL   = 8'sd100;
    localparam logic signed [c_PCT_W-1:0] c_PCT_HIGH   = 8'sd80;
    localparam logic signed [c_PCT_W-1:0] c_PCT_BAND   = 8'sd10;
    localparam logic signed [c_PCT_W-1:0] c_PCT_LOW    = 8'sd20;

    localparam logic [c_LEVEL_W-1:0] c_LEVEL_OVER  = 4'd0;
    localparam logic [c_LEVEL_W-1:0] c_LEVEL_HIGH  = 4'd1;
    localparam logic [c_LEVEL_W-1:0] c_LEVEL_EMPTY = 4'd8;

    typedef struct packed {
        logic [c_CODE_W-1:0] adc_code;
    } t_bvmm_in;

    typedef struct packed {
        logic [c_MV_W-1:0]           vcc_mv;
        logic signed [c_PCT_W-1:0]   percent;
        logic [c_LEVEL_W-1:0]        level;
        logic                        divide_error;
    } t_bvmm_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VDIV,
        S_VSAT,
        S_FWD,
        S_BWD,
        S_PSET,
        S_PDIV,
        S_PSAT,
        S_OUT
    } t_bvmm_state;

endpackage

FILE: rtl/bvmm_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one request payload of type T.
// Depends on nothing; payload types come from bvmm_pkg at instantiation.

interface bvmm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/battery_vcc_median_monitor.sv
`timescale 1ns / 1ps
// Supply monitor: ADC code to millivolts, running median over ENTRIES samples,
// charge percent and icon level. Uses bvmm_pkg and bvmm_stream_if.
// Work per request: up to two passes of the shared 24-step restoring divider
// plus the one-entry-a-cycle sorted insertion. One request at a time; the
// next is taken the cycle after the result register is loaded, and that load
// waits while the output is stalled. Synchronous reset clears the sample
// buffer, write slot, configuration registers (to their defaults) and the
// output valid.

module battery_vcc_median_monitor import bvmm_pkg::*; #(
    parameter int ENTRIES = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [c_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [c_CFG_DATA_W-1:0] i_cfg_data,
    bvmm_stream_if.sink             i_adc,
    bvmm_stream_if.source           o_res
);

    localparam int                IDX_W   = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0]  IDX_TOP = IDX_W'(ENTRIES - 1);
    localparam logic [IDX_W-1:0]  IDX_MED = IDX_W'(ENTRIES / 2);

    // Configuration registers
    logic [c_NUM_W-1:0] r_ref_num;
    logic [c_MV_W-1:0]  r_min_mv;
    logic [c_MV_W-1:0]  r_max_mv;

    // Sample buffer, kept sorted
    logic [c_MV_W-1:0]  r_buf [ENTRIES];
    logic               buf_we;
    logic [c_MV_W-1:0]  buf_wdata;
    logic [IDX_W-1:0]   rd_idx;
    logic [c_MV_W-1:0]  rd_data;
    logic               fwd_ok;
    logic               bwd_ok;

    // Sequencer and datapath registers
    t_bvmm_state               r_state, n_state;
    logic [4:0]                r_cnt, n_cnt;
    logic [c_NUM_W-1:0]        r_quo, n_quo;
    logic [c_MV_W-1:0]         r_rem, n_rem;
    logic [c_MV_W-1:0]         r_div, n_div;
    logic [c_MV_W-1:0]         r_sample, n_sample;
    logic                      r_err, n_err;
    logic                      r_neg, n_neg;
    logic [IDX_W-1:0]          r_pos, n_pos;
    logic [IDX_W-1:0]          r_slot, n_slot;
    logic signed [c_PCT_W-1:0] r_pct, n_pct;
    logic                      r_out_valid, n_out_valid;
    t_bvmm_out                 r_out, n_out;

    // Shared divider step
    logic [c_MV_W:0]    div_trial;
    logic [c_MV_W:0]    div_diff;
    logic               div_ge;
    logic [c_NUM_W-1:0] div_quo;
    logic [c_MV_W-1:0]  div_rem;

    // Percent set-up arithmetic
    logic signed [c_MV_W+1:0] pct_diff;
    logic signed [c_MV_W+1:0] pct_den;
    logic signed [c_MV_W+1:0] den_abs;
    logic signed [24:0]       pct_num;
    logic signed [24:0]       num_adj;
    logic signed [24:0]       num_abs;
    logic [24:0]              pct_mag;

    function automatic logic [c_LEVEL_W-1:0] level_of(input logic signed [c_PCT_W-1:0] p);
        logic [c_LEVEL_W-1:0] lv;
        if (p > c_PCT_FULL) begin
            lv = c_LEVEL_OVER;
        end else if (p > c_PCT_HIGH) begin
            lv = c_LEVEL_HIGH;
        end else if (p > c_PCT_HIGH - c_PCT_BAND) begin
            lv = 4'd2;
        end else if (p > c_PCT_HIGH - 8'sd2 * c_PCT_BAND) begin
            lv = 4'd3;
        end else if (p > c_PCT_HIGH - 8'sd3 * c_PCT_BAND) begin
            lv = 4'd4;
        end else if (p > c_PCT_HIGH - 8'sd4 * c_PCT_BAND) begin
            lv = 4'd5;
        end else if (p > c_PCT_HIGH - 8'sd5 * c_PCT_BAND) begin
            lv = 4'd6;
        end else if (p > c_PCT_LOW) begin
            lv = 4'd7;
        end else begin
            lv = c_LEVEL_EMPTY;
        end
        return lv;
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_num <= c_RST_REF_NUM;
            r_min_mv  <= c_RST_MIN_MV;
            r_max_mv  <= c_RST_MAX_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                c_REG_REF_NUM: r_ref_num <= i_cfg_data;
                c_REG_MIN_MV:  r_min_mv  <= i_cfg_data[c_MV_W-1:0];
                c_REG_MAX_MV:  r_max_mv  <= i_cfg_data[c_MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Buffer neighbour read: one entry per cycle
    assign rd_idx  = (r_state == S_FWD) ? r_pos + 1'b1 : r_pos - 1'b1;
    assign rd_data = r_buf[rd_idx];
    assign fwd_ok  = (r_pos < IDX_TOP);
    assign bwd_ok  = (r_pos != '0);

    // Restoring divider step: one quotient bit
    assign div_trial = {r_rem, r_quo[c_NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div});
    assign div_diff  = div_trial - {1'b0, r_div};
    assign div_quo   = {r_quo[c_NUM_W-2:0], div_ge};
    assign div_rem   = div_ge ? div_diff[c_MV_W-1:0] : div_trial[c_MV_W-1:0];

    // Percent numerator and denominator, sign folded onto the numerator
    assign pct_diff = $signed({2'b00, r_buf[IDX_MED]}) - $signed({2'b00, r_min_mv});
    assign pct_den  = $signed({2'b00, r_max_mv}) - $signed({2'b00, r_min_mv});
    assign pct_num  = 25'(pct_diff) * $signed({18'd0, c_PCT_SCALE});
    assign num_adj  = pct_den[c_MV_W+1] ? -pct_num : pct_num;
    assign den_abs  = pct_den[c_MV_W+1] ? -pct_den : pct_den;
    assign num_abs  = num_adj[24] ? -num_adj : num_adj;
    assign pct_mag  = 25'(r_quo) + 25'(|r_rem);

    // Sequencer: next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_sample    = r_sample;
        n_err       = r_err;
        n_neg       = r_neg;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_pct       = r_pct;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        buf_we      = 1'b0;
        buf_wdata   = r_sample;
        i_adc.ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_adc.valid) begin
                    n_err = (i_adc.payload.adc_code == '0);
                    if (i_adc.payload.adc_code == '0) begin
                        n_sample = '1;
                        n_pos    = r_slot;
                        n_state  = S_FWD;
                    end else begin
                        n_quo   = r_ref_num;
                        n_rem   = '0;
                        n_div   = {{(c_MV_W-c_CODE_W){1'b0}}, i_adc.payload.adc_code};
                        n_cnt   = '0;
                        n_state = S_VDIV;
                    end
                end
            end
            S_VDIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == c_DIV_LAST) begin
                    n_state = S_VSAT;
                end
            end
            S_VSAT: begin
                n_sample = (|r_quo[c_NUM_W-1:c_MV_W]) ? '1 : r_quo[c_MV_W-1:0];
                n_pos    = r_slot;
                n_state  = S_FWD;
            end
            // Move the hole up while the new sample is larger than its neighbour
            S_FWD: begin
                if (fwd_ok && (r_sample > rd_data)) begin
                    buf_we    = 1'b1;
                    buf_wdata = rd_data;
                    n_pos     = r_pos + 1'b1;
                end else begin
                    n_state = S_BWD;
                end
            end
            // Move the hole down, then drop the sample in
            S_BWD: begin
                buf_we = 1'b1;
                if (bwd_ok && (rd_data > r_sample)) begin
                    buf_wdata = rd_data;
                    n_pos     = r_pos - 1'b1;
                end else begin
                    buf_wdata = r_sample;
                    n_slot    = (r_slot == IDX_TOP) ? '0 : r_slot + 1'b1;
                    n_state   = S_PSET;
                end
            end
            S_PSET: begin
                if (pct_den == '0) begin
                    n_pct   = c_PCT_SAT_HI;
                    n_state = S_OUT;
                end else begin
                    n_quo   = num_abs[c_NUM_W-1:0];
                    n_rem   = '0;
                    n_div   = den_abs[c_MV_W-1:0];
                    n_neg   = num_adj[24];
                    n_cnt   = '0;
                    n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == c_DIV_LAST) begin
                    n_state = S_PSAT;
                end
            end
            // Floor and saturate
            S_PSAT: begin
                if (!r_neg) begin
                    n_pct = (r_quo > c_NUM_W'(c_PCT_SAT_HI)) ? c_PCT_SAT_HI
                                                             : $signed(r_quo[c_PCT_W-1:0]);
                end else begin
                    n_pct = (pct_mag > 25'd128) ? c_PCT_SAT_LO
                                                : $signed(8'(25'd0 - pct_mag));
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.vcc_mv       = r_buf[IDX_MED];
                    n_out.percent      = r_pct;
                    n_out.level        = level_of(r_pct);
                    n_out.divide_error = r_err;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_sample <= n_sample;
        r_err    <= n_err;
        r_neg    <= n_neg;
        r_pos    <= n_pos;
        r_pct    <= n_pct;
        r_out    <= n_out;
    end

    // Sorted buffer, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_buf[k] <= '0;
            end
        end else if (buf_we) begin
            r_buf[r_pos] <= buf_wdata;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule
